[src/cdsf_pkg.sv]
// ----------------------------------------------------------------------------
// cdsf_pkg
// Shared constants, codes and types of the critically damped spring follower.
// ----------------------------------------------------------------------------
package cdsf_pkg;

   localparam int FRAC_BITS_DEFAULT   = 16;
   localparam int MAX_STEP_MS_DEFAULT = 64;

   localparam int WORD_W  = 32;
   localparam int MS_W    = 8;
   localparam int STIFF_W = 9;

   localparam int MS_PER_SECOND = 1000;
   localparam int STIFF_MIN     = 1;
   localparam int STIFF_MAX     = 256;
   localparam int STIFF_DIV     = 8;
   localparam int STIFF_RESET   = 64;

   localparam int DT_DEPTH = 1 << MS_W;

   // operand pairs of the shared multiplier
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_W2 = 3'd0;  // w * w
   localparam logic [OP_W-1:0] OP_T1 = 3'd1;  // w2 * disp
   localparam logic [OP_W-1:0] OP_T2 = 3'd2;  // c * vel
   localparam logic [OP_W-1:0] OP_AV = 3'd3;  // acc * dt
   localparam logic [OP_W-1:0] OP_PV = 3'd4;  // vel * dt

   typedef logic [WORD_W-1:0] dt_table_type [DT_DEPTH];

   // step size per millisecond count, evaluated at elaboration
   function automatic dt_table_type dt_table(int frac_bits);
      dt_table_type t;
      for (int i = 0; i < DT_DEPTH; i++) begin
         t[i] = WORD_W'((longint'(i) << frac_bits) / MS_PER_SECOND);
      end
      return t;
   endfunction

   typedef struct packed {
      logic            accept;
      logic            mul_en;
      logic [OP_W-1:0] mul_op;
      logic            acc_load;
      logic            acc_sub;
      logic            vel_upd;
      logic            finish;
   } cmd_type;

   typedef struct packed {
      logic zero_step;
   } sts_type;

endpackage

[src/critically_damped_spring_follower.sv]
// ----------------------------------------------------------------------------
// critically_damped_spring_follower
// Fixed-point spring follower: pulls a position and velocity toward a target.
// ----------------------------------------------------------------------------
// usage:
//   req_ channel (valid/stall): target and elapsed milliseconds of one request.
//   rsp_ channel (valid/stall): position and velocity after that step.
//   csr_ channel (valid/ready): stiffness write, always ready, 0 is stored
//   as 1 and values above 256 as 256. write only while the block is idle.
// timing:
//   a request with nonzero elapsed time runs five products and four adds
//   one after another through a single 32x32 multiplier before rsp_valid.
//   a zero-time request skips the products and goes to the final write.
//   one request is in work at a time; req_stall is high while it runs, so
//   a new request is accepted only once the last one is finished.
//   the result sits in an output register, so a new request is accepted
//   while an earlier result waits; rsp_stall holds only the final write.
// reset:
//   synchronous; clears position and velocity to zero, stiffness to 64,
//   and drops rsp_valid.
// ----------------------------------------------------------------------------
module critically_damped_spring_follower #(
   parameter int FRAC_BITS   = cdsf_pkg::FRAC_BITS_DEFAULT,
   parameter int MAX_STEP_MS = cdsf_pkg::MAX_STEP_MS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [cdsf_pkg::WORD_W-1:0]   req_target,
   input  logic        [cdsf_pkg::MS_W-1:0]     req_delta_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [cdsf_pkg::WORD_W-1:0]   rsp_position,
   output logic signed [cdsf_pkg::WORD_W-1:0]   rsp_velocity,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [cdsf_pkg::STIFF_W-1:0]  csr_data
);

   cdsf_pkg::cmd_type cmd;
   cdsf_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   cdsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cdsf_datapath #(
      .FRAC_BITS   (FRAC_BITS),
      .MAX_STEP_MS (MAX_STEP_MS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_target     (req_target),
      .req_delta_ms   (req_delta_ms),
      .csr_write      (csr_valid && csr_ready),
      .csr_data       (csr_data),
      .rsp_position   (rsp_position),
      .rsp_velocity   (rsp_velocity)
   );

`ifndef SYNTHESIS
   // an accepted request keeps the input closed in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open right after an accepted request");

   // the result register is never reloaded over an untaken result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || !rsp_stall))
      else $error("result overwritten while stalled");

   // a new result appears only after the final step of a request
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.finish))
      else $error("result valid without a finished request");
`endif

endmodule

[src/cdsf_datapath.sv]
// ----------------------------------------------------------------------------
// cdsf_datapath
// State, stiffness register, shared multiplier and result register.
// ----------------------------------------------------------------------------
module cdsf_datapath #(
   parameter int FRAC_BITS   = cdsf_pkg::FRAC_BITS_DEFAULT,
   parameter int MAX_STEP_MS = cdsf_pkg::MAX_STEP_MS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cdsf_pkg::cmd_type                    cmd,
   output cdsf_pkg::sts_type                    sts,
   input  logic signed [cdsf_pkg::WORD_W-1:0]   req_target,
   input  logic        [cdsf_pkg::MS_W-1:0]     req_delta_ms,
   input  logic                                 csr_write,
   input  logic        [cdsf_pkg::STIFF_W-1:0]  csr_data,
   output logic signed [cdsf_pkg::WORD_W-1:0]   rsp_position,
   output logic signed [cdsf_pkg::WORD_W-1:0]   rsp_velocity
);

   localparam int W = cdsf_pkg::WORD_W;
   localparam int StiffShift = $clog2(cdsf_pkg::STIFF_DIV);
   localparam cdsf_pkg::dt_table_type DtTable = cdsf_pkg::dt_table(FRAC_BITS);

   logic        [cdsf_pkg::STIFF_W-1:0] stiff_ff, stiff_in;
   logic signed [W-1:0] pos_ff, pos_in;
   logic signed [W-1:0] vel_ff, vel_in;
   logic signed [W-1:0] disp_ff, disp_in;
   logic signed [W-1:0] dt_ff, dt_in;
   logic                zero_ff, zero_in;
   logic signed [W-1:0] prod_ff, prod_in;
   logic signed [W-1:0] acc_ff, acc_in;
   logic signed [W-1:0] rsp_position_ff, rsp_position_in;
   logic signed [W-1:0] rsp_velocity_ff, rsp_velocity_in;

   logic        [cdsf_pkg::MS_W-1:0] ms_sat;
   logic signed [W-1:0]   omega;
   logic signed [W-1:0]   damping;
   logic signed [W-1:0]   mul_a, mul_b;
   logic signed [2*W-1:0] mul_full;
   logic signed [W-1:0]   pos_next;

   assign omega   = (W'(stiff_ff) << (FRAC_BITS - StiffShift)) + (W'(2) << FRAC_BITS);
   assign damping = omega << 1;

   assign ms_sat = (req_delta_ms > cdsf_pkg::MS_W'(MAX_STEP_MS))
                 ? cdsf_pkg::MS_W'(MAX_STEP_MS) : req_delta_ms;

   always_comb begin
      unique case (cmd.mul_op)
         cdsf_pkg::OP_W2: begin mul_a = omega;   mul_b = omega;   end
         cdsf_pkg::OP_T1: begin mul_a = prod_ff; mul_b = disp_ff; end
         cdsf_pkg::OP_T2: begin mul_a = damping; mul_b = vel_ff;  end
         cdsf_pkg::OP_AV: begin mul_a = acc_ff;  mul_b = dt_ff;   end
         cdsf_pkg::OP_PV: begin mul_a = vel_ff;  mul_b = dt_ff;   end
         default:         begin mul_a = '0;      mul_b = '0;      end
      endcase
   end

   assign mul_full = mul_a * mul_b;
   assign pos_next = pos_ff + prod_ff;

   always_comb begin
      stiff_in = stiff_ff;
      if (csr_write) begin
         if (csr_data < cdsf_pkg::STIFF_W'(cdsf_pkg::STIFF_MIN)) begin
            stiff_in = cdsf_pkg::STIFF_W'(cdsf_pkg::STIFF_MIN);
         end else if (csr_data > cdsf_pkg::STIFF_W'(cdsf_pkg::STIFF_MAX)) begin
            stiff_in = cdsf_pkg::STIFF_W'(cdsf_pkg::STIFF_MAX);
         end else begin
            stiff_in = csr_data;
         end
      end

      disp_in = disp_ff;
      dt_in   = dt_ff;
      zero_in = zero_ff;
      if (cmd.accept) begin
         disp_in = pos_ff - req_target;
         dt_in   = DtTable[ms_sat];
         zero_in = (req_delta_ms == '0);
      end

      // floor shift of the full product, low word kept
      prod_in = cmd.mul_en ? mul_full[FRAC_BITS +: W] : prod_ff;

      acc_in = acc_ff;
      if (cmd.acc_load) begin
         acc_in = W'(0) - prod_ff;
      end else if (cmd.acc_sub) begin
         acc_in = acc_ff - prod_ff;
      end

      vel_in = cmd.vel_upd ? vel_ff + prod_ff : vel_ff;

      pos_in          = pos_ff;
      rsp_position_in = rsp_position_ff;
      rsp_velocity_in = rsp_velocity_ff;
      if (cmd.finish) begin
         if (!zero_ff) begin
            pos_in = pos_next;
         end
         rsp_position_in = zero_ff ? pos_ff : pos_next;
         rsp_velocity_in = vel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff <= cdsf_pkg::STIFF_W'(cdsf_pkg::STIFF_RESET);
         pos_ff   <= '0;
         vel_ff   <= '0;
         zero_ff  <= 1'b0;
      end else begin
         stiff_ff <= stiff_in;
         pos_ff   <= pos_in;
         vel_ff   <= vel_in;
         zero_ff  <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      disp_ff         <= disp_in;
      dt_ff           <= dt_in;
      prod_ff         <= prod_in;
      acc_ff          <= acc_in;
      rsp_position_ff <= rsp_position_in;
      rsp_velocity_ff <= rsp_velocity_in;
   end

   assign sts.zero_step = zero_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_velocity  = rsp_velocity_ff;

endmodule

[src/cdsf_ctrl.sv]
// ----------------------------------------------------------------------------
// cdsf_ctrl
// Sequencer of one step through the shared multiplier, and output handshake.
// ----------------------------------------------------------------------------
module cdsf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  cdsf_pkg::sts_type sts,
   output cdsf_pkg::cmd_type cmd
);

   localparam int StateW = 4;
   localparam logic [StateW-1:0] ST_IDLE = 4'd0;
   localparam logic [StateW-1:0] ST_W2   = 4'd1;
   localparam logic [StateW-1:0] ST_T1   = 4'd2;
   localparam logic [StateW-1:0] ST_T2   = 4'd3;
   localparam logic [StateW-1:0] ST_ACC  = 4'd4;
   localparam logic [StateW-1:0] ST_AV   = 4'd5;
   localparam logic [StateW-1:0] ST_VUP  = 4'd6;
   localparam logic [StateW-1:0] ST_PV   = 4'd7;
   localparam logic [StateW-1:0] ST_DONE = 4'd8;

   logic [StateW-1:0] state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;

   // result register may be reloaded when empty or drained this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_W2;
            end
         end
         ST_W2: begin
            if (sts.zero_step) begin
               state_in = ST_DONE;
            end else begin
               cmd.mul_en = 1'b1;
               cmd.mul_op = cdsf_pkg::OP_W2;
               state_in   = ST_T1;
            end
         end
         ST_T1: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = cdsf_pkg::OP_T1;
            state_in   = ST_T2;
         end
         ST_T2: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_op   = cdsf_pkg::OP_T2;
            cmd.acc_load = 1'b1;
            state_in     = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_sub = 1'b1;
            state_in    = ST_AV;
         end
         ST_AV: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = cdsf_pkg::OP_AV;
            state_in   = ST_VUP;
         end
         ST_VUP: begin
            cmd.vel_upd = 1'b1;
            state_in    = ST_PV;
         end
         ST_PV: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = cdsf_pkg::OP_PV;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
